// ===== hw/rtl/swfd_pkg.sv =====
// ============================================================================
// swfd_pkg
// Shared types and constants for the sliding window factor density block.
// ============================================================================
`default_nettype none

package swfd_pkg;

    localparam int CNT_W    = 13;   // factor count width
    localparam int IDX_W    = 32;   // window index width
    localparam int POS_W    = 32;   // position counter width
    localparam int DENS_W   = 36;   // Q20.16 density width
    localparam int SCALE_W  = 32;   // Q8.24 scale width
    localparam int WCFG_W   = 13;   // window_size register width
    localparam int STEP_W   = 16;   // step_size register width
    localparam int CFG_W    = 32;   // config data width
    localparam int CFG_IDX_W = 2;
    localparam int PROD_W   = CNT_W + SCALE_W;
    localparam int FRAC_SH  = 8;    // Q8.24 * int -> Q21.16

    localparam logic [CNT_W-1:0]  CNT_MAX   = {CNT_W{1'b1}};
    localparam logic [POS_W-1:0]  POS_MAX   = {POS_W{1'b1}};
    localparam logic [DENS_W-1:0] DENS_MAX  = {DENS_W{1'b1}};

    localparam logic [WCFG_W-1:0]  WSIZE_RST = WCFG_W'(1);
    localparam logic [STEP_W-1:0]  STEP_RST  = STEP_W'(1);
    localparam logic [SCALE_W-1:0] SCALE_RST = SCALE_W'(32'h0100_0000);

    // result queue
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = 3;
    localparam int FIFO_CW    = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_SIZE   = 2'd0,
        CFG_STEP_SIZE     = 2'd1,
        CFG_DENSITY_SCALE = 2'd2
    } t_cfg_idx;

    // per-item control handed to the ring stage
    typedef struct packed {
        logic             first;
        logic             bit_in;
        logic             leave_ok;
        logic             emit;
        logic             excl;
        logic [IDX_W-1:0] wnum;
    } t_item_ctl;

    // completed window, count resolved
    typedef struct packed {
        logic [IDX_W-1:0] wnum;
        logic [CNT_W-1:0] count;
        logic             excl;
    } t_win;

    typedef struct packed {
        logic [IDX_W-1:0]  window_index;
        logic [CNT_W-1:0]  factor_count;
        logic [DENS_W-1:0] density;
        logic              excluded;
    } t_result;

endpackage

`default_nettype wire

// ===== hw/rtl/swfd_if.sv =====
// ============================================================================
// swfd_if
// Valid/ready channels for position items and window results.
// ============================================================================
`default_nettype none

interface swfd_in_if;
    logic valid;
    logic ready;
    logic factor_start;
    logic first_position;
    logic window_excluded;

    modport source (output valid, factor_start, first_position, window_excluded,
                    input ready);
    modport sink   (input valid, factor_start, first_position, window_excluded,
                    output ready);
endinterface

interface swfd_out_if;
    logic                        valid;
    logic                        ready;
    logic [swfd_pkg::IDX_W-1:0]  window_index;
    logic [swfd_pkg::CNT_W-1:0]  factor_count;
    logic [swfd_pkg::DENS_W-1:0] density;
    logic                        excluded;

    modport source (output valid, window_index, factor_count, density, excluded,
                    input ready);
    modport sink   (input valid, window_index, factor_count, density, excluded,
                    output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/swfd_ring.sv =====
// ============================================================================
// swfd_ring
// Bit ring memory and running window count.
// ============================================================================
`default_nettype none

module swfd_ring #(
    parameter int MAX_WINDOW = 4096,
    parameter int AW         = 12,
    parameter int WW         = 13
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_acc,
    input  wire swfd_pkg::t_item_ctl i_ctl,
    input  wire logic [WW-1:0]       i_win,
    output logic                     o_s1_emit,
    output logic                     o_win_vld,
    output swfd_pkg::t_win           o_win
);

    localparam int SW = ((AW > WW) ? AW : WW) + 1;
    localparam logic [SW-1:0] MAX_EXT  = SW'(MAX_WINDOW);
    localparam logic [AW-1:0] PTR_LAST = AW'(MAX_WINDOW - 1);

    logic                 mem [MAX_WINDOW];
    logic [AW-1:0]        r_ptr, n_ptr;
    logic                 r_rd;
    logic                 r_s1_vld;
    swfd_pkg::t_item_ctl  r_s1;
    logic [swfd_pkg::CNT_W-1:0] r_count, n_count;
    logic                 r_s2_vld;
    swfd_pkg::t_win       r_s2;

    logic [SW-1:0] ptr_ext, w_ext, raddr_full;
    logic [AW-1:0] raddr;
    logic [swfd_pkg::CNT_W-1:0] base, c1;
    logic          inc, dec;

    // slot that leaves the window: ptr - w modulo the ring depth
    always_comb begin
        ptr_ext    = SW'(r_ptr);
        w_ext      = SW'(i_win);
        raddr_full = (ptr_ext >= w_ext) ? (ptr_ext - w_ext) : (ptr_ext + MAX_EXT - w_ext);
        raddr      = raddr_full[AW-1:0];
        n_ptr      = (r_ptr == PTR_LAST) ? '0 : r_ptr + AW'(1);
    end

    // read-before-write covers w == depth, where both hit the same slot
    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            mem[r_ptr] <= i_ctl.bit_in;
            r_rd       <= mem[raddr];
            r_s1       <= i_ctl;
        end
    end

    always_comb begin
        base    = r_s1.first ? '0 : r_count;
        inc     = r_s1.bit_in && (base != swfd_pkg::CNT_MAX);
        c1      = base + swfd_pkg::CNT_W'(inc);
        dec     = r_s1.leave_ok && r_rd && (c1 != '0);
        n_count = r_s1_vld ? (c1 - swfd_pkg::CNT_W'(dec)) : r_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr    <= '0;
            r_s1_vld <= 1'b0;
            r_count  <= '0;
            r_s2_vld <= 1'b0;
        end else begin
            if (i_acc) begin
                r_ptr <= n_ptr;
            end
            r_s1_vld <= i_acc;
            r_count  <= n_count;
            r_s2_vld <= r_s1_vld && r_s1.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_vld && r_s1.emit) begin
            r_s2.wnum  <= r_s1.wnum;
            r_s2.count <= n_count;
            r_s2.excl  <= r_s1.excl;
        end
    end

    assign o_s1_emit = r_s1_vld && r_s1.emit;
    assign o_win_vld = r_s2_vld;
    assign o_win     = r_s2;

endmodule

`default_nettype wire

// ===== hw/rtl/swfd_scale.sv =====
// ============================================================================
// swfd_scale
// Density scaling: count times Q8.24 scale, shift to Q21.16, saturate to Q20.16.
// ============================================================================
`default_nettype none

module swfd_scale (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_win_vld,
    input  wire swfd_pkg::t_win                i_win,
    input  wire logic [swfd_pkg::SCALE_W-1:0]  i_scale,
    output logic                               o_res_vld,
    output swfd_pkg::t_result                  o_res
);

    localparam int SH_W = swfd_pkg::PROD_W - swfd_pkg::FRAC_SH;

    logic                          r_vld;
    logic [swfd_pkg::PROD_W-1:0]   r_prod;
    swfd_pkg::t_win                r_win;
    logic [SH_W-1:0]               shifted;
    logic [swfd_pkg::DENS_W-1:0]   dens;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_win_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_win_vld) begin
            r_prod <= swfd_pkg::PROD_W'(i_win.count) * swfd_pkg::PROD_W'(i_scale);
            r_win  <= i_win;
        end
    end

    always_comb begin
        shifted = r_prod[swfd_pkg::PROD_W-1:swfd_pkg::FRAC_SH];
        if (|shifted[SH_W-1:swfd_pkg::DENS_W]) begin
            dens = swfd_pkg::DENS_MAX;
        end else begin
            dens = shifted[swfd_pkg::DENS_W-1:0];
        end
        o_res.window_index = r_win.wnum;
        o_res.factor_count = r_win.count;
        o_res.density      = r_win.excl ? '0 : dens;
        o_res.excluded     = r_win.excl;
    end

    assign o_res_vld = r_vld;

endmodule

`default_nettype wire

// ===== hw/rtl/swfd_ofifo.sv =====
// ============================================================================
// swfd_ofifo
// Result queue between the pipeline and the output channel.
// ============================================================================
`default_nettype none

module swfd_ofifo (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_push,
    input  wire swfd_pkg::t_result              i_data,
    input  wire logic                           i_pop_rdy,
    output logic                                o_vld,
    output swfd_pkg::t_result                   o_data,
    output logic [swfd_pkg::FIFO_CW-1:0]        o_cnt
);

    swfd_pkg::t_result               q [swfd_pkg::FIFO_DEPTH];
    logic [swfd_pkg::FIFO_AW-1:0]    r_wptr, r_rptr;
    logic [swfd_pkg::FIFO_CW-1:0]    r_cnt;
    logic                            pop;

    assign o_vld  = (r_cnt != '0);
    assign pop    = o_vld && i_pop_rdy;
    assign o_data = q[r_rptr];
    assign o_cnt  = r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            q[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + swfd_pkg::FIFO_AW'(1);
            end
            if (pop) begin
                r_rptr <= r_rptr + swfd_pkg::FIFO_AW'(1);
            end
            r_cnt <= r_cnt + swfd_pkg::FIFO_CW'(i_push) - swfd_pkg::FIFO_CW'(pop);
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sliding_window_factor_density_top.sv =====
// ============================================================================
// sliding_window_factor_density_top
// Windowed factor-start count with scaled density per completed window.
// ============================================================================
//  port      dir  kind        contents
//  i_in      in   valid/ready factor_start, first_position, window_excluded
//  o_out     out  valid/ready window_index, factor_count, density, excluded
//  i_cfg_*   in   write only  window_size, step_size, density_scale
//
//  One item per cycle while the result queue has room; the ring memory is read
//  and written once per item and the running count is updated from the ring read.
//  A result is registered at the ring read, count, multiply and result queue.
//  Reset clears counters, ring pointer and queue; ring contents are not
//  cleared (no clearing pass, items accepted right after reset).
//  i_in.ready drops only when the 8-entry result queue plus in-flight
//  results would overflow, so output stalls are absorbed there.
// ============================================================================
`default_nettype none

module sliding_window_factor_density_top #(
    parameter int MAX_WINDOW = 4096
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    swfd_in_if.sink                                  i_in,
    swfd_out_if.source                               o_out,
    input  wire logic                                i_cfg_we,
    input  wire logic [swfd_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [swfd_pkg::CFG_W-1:0]          i_cfg_data
);

    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int WW = $clog2(MAX_WINDOW + 1);
    localparam logic [31:0] MAX_W32 = 32'(MAX_WINDOW);

    logic [swfd_pkg::WCFG_W-1:0]  r_wsize;
    logic [swfd_pkg::STEP_W-1:0]  r_step;
    logic [swfd_pkg::SCALE_W-1:0] r_scale;

    logic [swfd_pkg::POS_W-1:0]   r_pos, n_pos;
    logic [swfd_pkg::STEP_W-1:0]  r_phase, n_phase;
    logic [swfd_pkg::IDX_W-1:0]   r_wnum, n_wnum;

    logic                  acc;
    logic [31:0]           w32;
    logic [WW-1:0]         w;
    logic [swfd_pkg::STEP_W-1:0] k, sp, sp0;
    logic [swfd_pkg::STEP_W:0]   sp1;
    logic [swfd_pkg::POS_W-1:0]  p;
    logic [swfd_pkg::IDX_W-1:0]  wn;
    logic                  in_win;
    swfd_pkg::t_item_ctl   ctl;

    logic                  s1_emit;
    logic                  win_vld;
    swfd_pkg::t_win        win;
    logic                  res_vld;
    swfd_pkg::t_result     res;
    logic                  q_vld;
    swfd_pkg::t_result     q_data;
    logic [swfd_pkg::FIFO_CW-1:0] q_cnt;
    logic [swfd_pkg::FIFO_CW:0]   pending;

    // config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wsize <= swfd_pkg::WSIZE_RST;
            r_step  <= swfd_pkg::STEP_RST;
            r_scale <= swfd_pkg::SCALE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                swfd_pkg::CFG_WINDOW_SIZE:   r_wsize <= i_cfg_data[swfd_pkg::WCFG_W-1:0];
                swfd_pkg::CFG_STEP_SIZE:     r_step  <= i_cfg_data[swfd_pkg::STEP_W-1:0];
                swfd_pkg::CFG_DENSITY_SCALE: r_scale <= i_cfg_data[swfd_pkg::SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // results still to land in the queue count against its free space
    assign pending   = (swfd_pkg::FIFO_CW+1)'(q_cnt) + (swfd_pkg::FIFO_CW+1)'(s1_emit)
                     + (swfd_pkg::FIFO_CW+1)'(win_vld) + (swfd_pkg::FIFO_CW+1)'(res_vld);
    assign i_in.ready = (pending < (swfd_pkg::FIFO_CW+1)'(swfd_pkg::FIFO_DEPTH));
    assign acc        = i_in.valid && i_in.ready;

    // window position bookkeeping for the accepted item
    always_comb begin
        if (r_wsize == '0) begin
            w32 = 32'd1;
        end else if (32'(r_wsize) > MAX_W32) begin
            w32 = MAX_W32;
        end else begin
            w32 = 32'(r_wsize);
        end
        w = WW'(w32);
        k = (r_step == '0) ? swfd_pkg::STEP_W'(1) : r_step;

        p      = i_in.first_position ? '0 : r_pos;
        sp     = i_in.first_position ? '0 : r_phase;
        wn     = i_in.first_position ? '0 : r_wnum;
        in_win = (p >= (w32 - 32'd1));
        sp0    = (sp >= k) ? '0 : sp;
        sp1    = {1'b0, sp0} + (swfd_pkg::STEP_W+1)'(1);

        ctl.first    = i_in.first_position;
        ctl.bit_in   = i_in.factor_start || i_in.first_position;
        ctl.leave_ok = (p >= w32);
        ctl.emit     = in_win && (sp0 == '0);
        ctl.excl     = i_in.window_excluded;
        ctl.wnum     = wn;

        if (in_win) begin
            n_phase = (sp1 >= {1'b0, k}) ? '0 : sp1[swfd_pkg::STEP_W-1:0];
        end else begin
            n_phase = sp;
        end
        n_wnum = wn + swfd_pkg::IDX_W'(ctl.emit);
        n_pos  = (p == swfd_pkg::POS_MAX) ? p : p + swfd_pkg::POS_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_phase <= '0;
            r_wnum  <= '0;
        end else if (acc) begin
            r_pos   <= n_pos;
            r_phase <= n_phase;
            r_wnum  <= n_wnum;
        end
    end

    swfd_ring #(
        .MAX_WINDOW (MAX_WINDOW),
        .AW         (AW),
        .WW         (WW)
    ) u_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_acc     (acc),
        .i_ctl     (ctl),
        .i_win     (w),
        .o_s1_emit (s1_emit),
        .o_win_vld (win_vld),
        .o_win     (win)
    );

    swfd_scale u_scale (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_win_vld (win_vld),
        .i_win     (win),
        .i_scale   (r_scale),
        .o_res_vld (res_vld),
        .o_res     (res)
    );

    swfd_ofifo u_ofifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (res_vld),
        .i_data    (res),
        .i_pop_rdy (o_out.ready),
        .o_vld     (q_vld),
        .o_data    (q_data),
        .o_cnt     (q_cnt)
    );

    assign o_out.valid        = q_vld;
    assign o_out.window_index = q_data.window_index;
    assign o_out.factor_count = q_data.factor_count;
    assign o_out.density      = q_data.density;
    assign o_out.excluded     = q_data.excluded;

endmodule

`default_nettype wire

// ===== hw/rtl/swfd_checker.sv =====
// ============================================================================
// swfd_checker
// Port-level checks on the result channel, bound to the top level.
// ============================================================================
`default_nettype none

module swfd_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_out_valid,
    input wire logic                        i_out_ready,
    input wire logic [swfd_pkg::IDX_W-1:0]  i_window_index,
    input wire logic [swfd_pkg::CNT_W-1:0]  i_factor_count,
    input wire logic [swfd_pkg::DENS_W-1:0] i_density,
    input wire logic                        i_excluded
);

    // nothing comes out in the cycle after reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_excl_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_excluded |-> i_density == '0)
        else $error("excluded window with nonzero density");

    a_cnt_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_factor_count == '0 |-> i_density == '0)
        else $error("empty window with nonzero density");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_window_index)
            && $stable(i_factor_count) && $stable(i_density) && $stable(i_excluded))
        else $error("stalled result changed");

endmodule

bind sliding_window_factor_density_top swfd_checker u_swfd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_window_index (o_out.window_index),
    .i_factor_count (o_out.factor_count),
    .i_density      (o_out.density),
    .i_excluded     (o_out.excluded)
);

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Self-checking bench for the sliding window factor density block. A short
// table of directed items and register writes comes first, then random
// sequences over a range of window, step and scale settings. Every accepted
// item runs through a local window-count model; each result taken from the
// block is compared field by field with the oldest predicted window.
// ============================================================================

module testbench;

    localparam int MAXW         = 4096;
    localparam int DRAIN_CYCLES = 10;    // pipeline is four deep, plus margin
    localparam int STALL_LIMIT  = 4000;  // cycles without any item moving
    localparam int MAX_REPORTS  = 100;

    typedef enum logic {ROW_ITEM, ROW_REG} t_row_kind;

    typedef struct packed {
        t_row_kind                       kind;
        logic                            fs;
        logic                            first;
        logic                            ex;
        logic                            has_lit;
        swfd_pkg::t_result               lit;
        swfd_pkg::t_cfg_idx              idx;
        logic [swfd_pkg::CFG_W-1:0]      data;
    } t_row;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           cfg_we;
    logic [swfd_pkg::CFG_IDX_W-1:0] cfg_idx;
    logic [swfd_pkg::CFG_W-1:0]     cfg_data;

    swfd_in_if  in_if ();
    swfd_out_if out_if ();

    sliding_window_factor_density_top #(
        .MAX_WINDOW (MAXW)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // shadow registers and window-count state
    logic [swfd_pkg::WCFG_W-1:0]  shadow_window = swfd_pkg::WSIZE_RST;
    logic [swfd_pkg::STEP_W-1:0]  shadow_step   = swfd_pkg::STEP_RST;
    logic [swfd_pkg::SCALE_W-1:0] shadow_scale  = swfd_pkg::SCALE_RST;

    logic                         ring_bits [MAXW];
    int unsigned                  ring_wr      = 0;
    logic [swfd_pkg::CNT_W-1:0]   win_count    = '0;
    logic [swfd_pkg::POS_W-1:0]   seq_pos      = '0;
    int unsigned                  stride_phase = 0;
    logic [swfd_pkg::IDX_W-1:0]   win_num      = '0;

    swfd_pkg::t_result pending_windows [$];
    t_row              dir_rows [$];

    int send_idle_pct = 29;
    int recv_idle_pct = 45;
    int mismatch_cnt  = 0;
    int idle_cycles   = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Advance the window count by one position; returns 1 when a window closes.
    function automatic bit advance_window(input logic fs, input logic first,
                                          input logic ex, output swfd_pkg::t_result r);
        int unsigned                w;
        int unsigned                k;
        logic                       bit_in;
        logic                       leave;
        logic [swfd_pkg::POS_W-1:0] p;
        logic [63:0]                prod;
        bit                         hit;
        w = shadow_window;
        if (w < 1) w = 1;
        if (w > MAXW) w = MAXW;
        k = shadow_step;
        if (k < 1) k = 1;
        hit = 1'b0;
        r = '0;
        if (first) begin
            win_count    = '0;
            seq_pos      = '0;
            stride_phase = 0;
            win_num      = '0;
        end
        p = seq_pos;
        bit_in = fs | first;
        leave = 1'b0;
        if (p >= w) leave = ring_bits[(ring_wr + MAXW - w) % MAXW];
        ring_bits[ring_wr] = bit_in;
        ring_wr = (ring_wr + 1) % MAXW;
        if (bit_in && win_count != swfd_pkg::CNT_MAX) win_count = win_count + 1'b1;
        if (leave && win_count != '0) win_count = win_count - 1'b1;
        if (p >= w - 1) begin
            if (stride_phase >= k) stride_phase = 0;
            if (stride_phase == 0) begin
                prod = (64'(win_count) * 64'(shadow_scale)) >> swfd_pkg::FRAC_SH;
                r.window_index = win_num;
                r.factor_count = win_count;
                r.excluded     = ex;
                if (ex) r.density = '0;
                else if (prod > 64'(swfd_pkg::DENS_MAX)) r.density = swfd_pkg::DENS_MAX;
                else r.density = prod[swfd_pkg::DENS_W-1:0];
                win_num = win_num + 1'b1;
                hit = 1'b1;
            end
            stride_phase = stride_phase + 1;
            if (stride_phase >= k) stride_phase = 0;
        end
        if (seq_pos != swfd_pkg::POS_MAX) seq_pos = seq_pos + 1'b1;
        return hit;
    endfunction

    function automatic t_row item_row(input logic fs, input logic first, input logic ex);
        t_row row;
        row = '0;
        row.kind  = ROW_ITEM;
        row.fs    = fs;
        row.first = first;
        row.ex    = ex;
        return row;
    endfunction

    function automatic t_row checked_row(input logic fs, input logic first, input logic ex,
                                         input logic [swfd_pkg::IDX_W-1:0] idx,
                                         input logic [swfd_pkg::CNT_W-1:0] cnt,
                                         input logic [swfd_pkg::DENS_W-1:0] dens,
                                         input logic exc);
        t_row row;
        row = item_row(fs, first, ex);
        row.has_lit = 1'b1;
        row.lit.window_index = idx;
        row.lit.factor_count = cnt;
        row.lit.density      = dens;
        row.lit.excluded     = exc;
        return row;
    endfunction

    function automatic t_row reg_row(input swfd_pkg::t_cfg_idx idx,
                                     input logic [swfd_pkg::CFG_W-1:0] data);
        t_row row;
        row = '0;
        row.kind = ROW_REG;
        row.idx  = idx;
        row.data = data;
        return row;
    endfunction

    task automatic add_row(input t_row row);
        dir_rows = {dir_rows, row};
    endtask

    task automatic expect_window(input swfd_pkg::t_result r);
        pending_windows = {pending_windows, r};
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatch_cnt < MAX_REPORTS)
            $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
        mismatch_cnt++;
    endtask

    // Hold the sender until every predicted window has come out.
    task automatic wait_windows_out();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_windows.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input swfd_pkg::t_cfg_idx idx,
                             input logic [swfd_pkg::CFG_W-1:0] data);
        wait_windows_out();
        // items that close no window may still be in the pipe
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            swfd_pkg::CFG_WINDOW_SIZE:   shadow_window = data[swfd_pkg::WCFG_W-1:0];
            swfd_pkg::CFG_STEP_SIZE:     shadow_step   = data[swfd_pkg::STEP_W-1:0];
            swfd_pkg::CFG_DENSITY_SCALE: shadow_scale  = data[swfd_pkg::SCALE_W-1:0];
            default: ;
        endcase
        cfg_we <= 1'b0;
    endtask

    task automatic send_item(input logic fs, input logic first, input logic ex,
                             input logic has_lit, input swfd_pkg::t_result lit);
        swfd_pkg::t_result win_r;
        bit                hit;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid           <= 1'b1;
        in_if.factor_start    <= fs;
        in_if.first_position  <= first;
        in_if.window_excluded <= ex;
        do @(posedge i_clk); while (!in_if.ready);
        hit = advance_window(fs, first, ex, win_r);
        if (has_lit) expect_window(lit);
        else if (hit) expect_window(win_r);
    endtask

    // Mostly sequences opened by a first position, some continuation noise.
    task automatic run_phase(input logic [swfd_pkg::CFG_W-1:0] w,
                             input logic [swfd_pkg::CFG_W-1:0] step,
                             input logic [swfd_pkg::CFG_W-1:0] scale, input int items,
                             input int fs_pct, input int seq_max);
        int sent;
        int len;
        bit start_new;
        write_reg(swfd_pkg::CFG_WINDOW_SIZE, w);
        write_reg(swfd_pkg::CFG_STEP_SIZE, step);
        write_reg(swfd_pkg::CFG_DENSITY_SCALE, scale);
        sent = 0;
        while (sent < items) begin
            start_new = (sent == 0) || ($urandom_range(0, 99) < 85);
            len = $urandom_range(1, seq_max);
            if (len > items - sent) len = items - sent;
            for (int i = 0; i < len; i++) begin
                send_item($urandom_range(0, 99) < fs_pct, start_new && i == 0,
                          $urandom_range(0, 99) < 20, 1'b0, '0);
                sent++;
                if (sent == items / 2) wait_windows_out();
            end
        end
    endtask

    always @(posedge i_clk) begin
        out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    always @(posedge i_clk) begin
        swfd_pkg::t_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_windows.size() == 0) begin
                report_mismatch("unexpected window", out_if.window_index, '0);
            end else begin
                want = pending_windows.pop_front();
                if (out_if.window_index !== want.window_index)
                    report_mismatch("window_index", out_if.window_index, want.window_index);
                if (out_if.factor_count !== want.factor_count)
                    report_mismatch("factor_count", out_if.factor_count, want.factor_count);
                if (out_if.density !== want.density)
                    report_mismatch("density", out_if.density, want.density);
                if (out_if.excluded !== want.excluded)
                    report_mismatch("excluded", out_if.excluded, want.excluded);
            end
        end
    end

    initial begin
        while (idle_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        foreach (ring_bits[i]) ring_bits[i] = 1'b0;
        i_rst_n               = 1'b0;
        cfg_we                = 1'b0;
        cfg_idx               = '0;
        cfg_data              = '0;
        in_if.valid           = 1'b0;
        in_if.factor_start    = 1'b0;
        in_if.first_position  = 1'b0;
        in_if.window_excluded = 1'b0;
        out_if.ready          = 1'b0;

        // reset settings: window 1, step 1, scale 1.0, so each item closes a window
        // stream before any first position: no forced factor start
        add_row(checked_row(1'b0, 1'b0, 1'b0, 32'd0, 13'd0, 36'h0, 1'b0));
        add_row(checked_row(1'b1, 1'b0, 1'b0, 32'd1, 13'd1, 36'h10000, 1'b0));
        add_row(checked_row(1'b1, 1'b0, 1'b1, 32'd2, 13'd1, 36'h0, 1'b1));
        // first position counts as a factor start and restarts numbering
        add_row(checked_row(1'b0, 1'b1, 1'b0, 32'd0, 13'd1, 36'h10000, 1'b0));
        add_row(checked_row(1'b0, 1'b0, 1'b0, 32'd1, 13'd0, 36'h0, 1'b0));
        add_row(checked_row(1'b1, 1'b1, 1'b1, 32'd0, 13'd1, 36'h0, 1'b1));
        // zero window and zero step both act as 1
        add_row(reg_row(swfd_pkg::CFG_WINDOW_SIZE, 32'd0));
        add_row(checked_row(1'b1, 1'b0, 1'b0, 32'd1, 13'd1, 36'h10000, 1'b0));
        add_row(reg_row(swfd_pkg::CFG_STEP_SIZE, 32'd0));
        add_row(checked_row(1'b0, 1'b0, 1'b0, 32'd2, 13'd0, 36'h0, 1'b0));
        add_row(reg_row(swfd_pkg::CFG_DENSITY_SCALE, 32'hFFFF_FFFF));
        add_row(checked_row(1'b1, 1'b0, 1'b0, 32'd3, 13'd1, 36'h0FF_FFFF, 1'b0));
        add_row(reg_row(swfd_pkg::CFG_DENSITY_SCALE, 32'd0));
        add_row(checked_row(1'b1, 1'b0, 1'b0, 32'd4, 13'd1, 36'h0, 1'b0));
        // window 3, step 2: bits leave the window, every other position closes one
        add_row(reg_row(swfd_pkg::CFG_WINDOW_SIZE, 32'd3));
        add_row(reg_row(swfd_pkg::CFG_STEP_SIZE, 32'd2));
        add_row(reg_row(swfd_pkg::CFG_DENSITY_SCALE, 32'h0100_0000));
        add_row(item_row(1'b0, 1'b1, 1'b0));
        add_row(item_row(1'b1, 1'b0, 1'b0));
        add_row(item_row(1'b0, 1'b0, 1'b0));
        add_row(item_row(1'b1, 1'b0, 1'b0));
        add_row(item_row(1'b1, 1'b0, 1'b1));
        add_row(item_row(1'b0, 1'b0, 1'b1));
        add_row(item_row(1'b0, 1'b0, 1'b0));

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 29;
        recv_idle_pct = 45;
        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_REG)
                write_reg(dir_rows[i].idx, dir_rows[i].data);
            else
                send_item(dir_rows[i].fs, dir_rows[i].first, dir_rows[i].ex,
                          dir_rows[i].has_lit, dir_rows[i].lit);
        end

        run_phase(32'd1, 32'd1, 32'h0100_0000, 120, $urandom_range(10, 90), 12);
        run_phase(32'd2, 32'd1, $urandom(), 120, $urandom_range(10, 90), 12);
        run_phase(32'd5, 32'd3, $urandom(), 120, $urandom_range(10, 90), 24);
        run_phase(32'd8, 32'd8, $urandom(), 120, $urandom_range(10, 90), 40);

        send_idle_pct = 45;
        recv_idle_pct = 29;
        run_phase(32'd3, 32'd7, $urandom(), 120, $urandom_range(10, 90), 30);
        run_phase(32'd16, 32'd1, 32'hFFFF_FFFF, 150, $urandom_range(10, 90), 50);
        run_phase(32'd10, 32'd65535, $urandom(), 150, $urandom_range(10, 90), 40);
        run_phase(32'd4, 32'd2, 32'd0, 120, $urandom_range(10, 90), 16);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_phase($urandom_range(1, 12), $urandom_range(1, 6), $urandom(), 120,
                  $urandom_range(10, 90), 30);

        wait_windows_out();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0 && pending_windows.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/swfd_pkg.sv
hw/rtl/swfd_if.sv
hw/rtl/swfd_ring.sv
hw/rtl/swfd_scale.sv
hw/rtl/swfd_ofifo.sv
hw/rtl/sliding_window_factor_density_top.sv
hw/rtl/swfd_checker.sv
bench/testbench.sv
